>>> rtl/core/aligned_bump_page_allocator_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the aligned bump page allocator
// Concurrent assertion wrappers; they compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ALIGNED_BUMP_PAGE_ALLOCATOR_MACROS_SVH
`define ALIGNED_BUMP_PAGE_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge, skipped while reset is high.
`define ABPA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define ABPA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ABPA_ASSERT(label, clk, rst, prop, msg)
`define ABPA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> rtl/core/abpa_pkg.sv
// ---------------------------------------------------------------------------
// Aligned bump page allocator package
// Sizes, command and status codes, and the bump datapath result type.
// ---------------------------------------------------------------------------
package abpa_pkg;

  localparam int PAGE_BITS   = 12;
  localparam int STACK_ORDER = 2;
  localparam int CACHE_DEPTH = 16;
  localparam int ADDR_BITS   = 48;

  localparam int FIELD_W   = 48;
  localparam int NP_W      = 36;
  localparam int CMD_W     = 2;
  localparam int PCNT_W    = 16;
  localparam int ORDER_W   = 5;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  // Largest block is 2^(2^ORDER_W - 1) pages.
  localparam int PAGES_W = 1 << ORDER_W;
  localparam int LOW_W   = PAGE_BITS + STACK_ORDER;
  localparam int PAD_W   = STACK_ORDER + 1;
  localparam int SHIFT_W = NP_W + PAGE_BITS;
  localparam int WIDE_W  = ((SHIFT_W > FIELD_W) ? SHIFT_W : FIELD_W) + 1;
  localparam int CNT_W   = $clog2(CACHE_DEPTH + 1);
  localparam int IDX_W   = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

  localparam logic [NP_W-1:0] NP_MAX    = {NP_W{1'b1}};
  localparam logic [63:0]     ADDR_MASK = (ADDR_BITS >= 64) ? {64{1'b1}}
                                          : ((64'd1 << ADDR_BITS) - 64'd1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC         = 2'd0,
    CMD_ALLOC_ALIGNED = 2'd1,
    CMD_FREE          = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_IGNORED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REGION_BASE = 1'd0,
    REG_REGION_SIZE = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [FIELD_W-1:0] addr;
    logic               oom;
    logic [NP_W-1:0]    next_page;
  } bump_res_t;

endpackage

>>> rtl/core/aligned_bump_page_allocator.sv
// ---------------------------------------------------------------------------
// Aligned bump page allocator
// Hands out pages from one region, with aligned blocks and a LIFO cache of
// freed blocks of the cached order.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: drive cmd, page_count, order and block_addr with start
//   high; the transaction is taken at a rising edge where busy is low. busy
//   is low except during reset, so a request may enter on every cycle.
//   Result channel: done pulses for exactly one cycle with addr and status;
//   the receiver cannot stall, so every result must be taken as it appears.
//   Pipeline: one input register stage, then one result register stage,
//   between the accepting edge and the done cycle.
//   Throughput: one request per cycle; the counter pad, address add and
//   limit compare, or the cache push or pop, all finish in the single compute
//   stage, so back-to-back requests see each other's state updates.
//   Configuration: cfg_index selects region_base (0) or region_size (1);
//   a write is taken when cfg_valid and cfg_ready are high. Write only while
//   no request is in flight.
//   Reset (synchronous, rst high): clears the region registers, the page
//   counter, the cache fill count and any request in flight. The cache
//   contents are not cleared; only entries below the fill count are read.
// ---------------------------------------------------------------------------
`include "aligned_bump_page_allocator_macros.svh"

module aligned_bump_page_allocator import abpa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     cmd,
  input  logic [PCNT_W-1:0]    page_count,
  input  logic [ORDER_W-1:0]   order,
  input  logic [FIELD_W-1:0]   block_addr,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FIELD_W-1:0]   cfg_data,
  // result channel
  output logic                 done,
  output logic [FIELD_W-1:0]   addr,
  output logic [STATUS_W-1:0]  status
);

  // Configuration registers
  logic [FIELD_W-1:0] region_base;
  logic [FIELD_W-1:0] region_size;

  // Allocator state
  logic [NP_W-1:0]    next_page;
  logic [NP_W-1:0]    next_page_next;
  logic [CNT_W-1:0]   free_stack_count;
  logic [CNT_W-1:0]   free_stack_count_next;
  logic [CNT_W-1:0]   count_dec;
  logic [FIELD_W-1:0] free_stack_store [CACHE_DEPTH];
  logic               push;

  // Input register stage
  logic               req_valid;
  logic [CMD_W-1:0]   req_cmd;
  logic [PCNT_W-1:0]  req_page_count;
  logic [ORDER_W-1:0] req_order;
  logic [FIELD_W-1:0] req_block_addr;

  // Result next values
  logic [FIELD_W-1:0] addr_next;
  status_t            status_next;

  bump_res_t          bump;
  logic               accept;

  // Hold off requests and config writes only while reset is applied.
  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  // Capture the request transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_cmd        <= cmd;
      req_page_count <= page_count;
      req_order      <= order;
      req_block_addr <= block_addr;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= '0;
      region_size <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_REGION_BASE: region_base <= cfg_data;
        REG_REGION_SIZE: region_size <= cfg_data;
      endcase
    end
  end

  // Pad, address and counter advance for both allocation commands.
  abpa_bump u_bump (
    .base       (region_base),
    .size       (region_size),
    .next_page  (next_page),
    .aligned    (cmd_t'(req_cmd) == CMD_ALLOC_ALIGNED),
    .page_count (req_page_count),
    .order      (req_order),
    .res        (bump)
  );

  assign count_dec = free_stack_count - CNT_W'(1);

  // Decode the registered request.
  always_comb begin
    next_page_next        = next_page;
    free_stack_count_next = free_stack_count;
    push                  = 1'b0;
    addr_next             = '0;
    status_next           = ST_OK;
    case (cmd_t'(req_cmd))
      CMD_ALLOC: begin
        next_page_next = bump.next_page;
        addr_next      = bump.addr;
        status_next    = bump.oom ? ST_OOM : ST_OK;
      end
      CMD_ALLOC_ALIGNED: begin
        if (req_order == ORDER_W'(STACK_ORDER) && free_stack_count != '0) begin
          // Cache hit: pop the most recent free, leave the counter alone.
          free_stack_count_next = count_dec;
          addr_next             = free_stack_store[count_dec[IDX_W-1:0]];
        end else begin
          next_page_next = bump.next_page;
          addr_next      = bump.addr;
          status_next    = bump.oom ? ST_OOM : ST_OK;
        end
      end
      CMD_FREE: begin
        if (req_order != ORDER_W'(STACK_ORDER)) begin
          status_next = ST_IGNORED;
        end else if (free_stack_count >= CNT_W'(CACHE_DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          push                  = 1'b1;
          free_stack_count_next = free_stack_count + CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_IGNORED;
      end
    endcase
  end

  // Commit state and register the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_page        <= '0;
      free_stack_count <= '0;
      done             <= 1'b0;
    end else begin
      done <= req_valid;
      if (req_valid) begin
        next_page        <= next_page_next;
        free_stack_count <= free_stack_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      addr   <= addr_next;
      status <= status_next;
    end
  end

  // Push a freed block onto the cache.
  always_ff @(posedge clk) begin
    if (req_valid && push) begin
      free_stack_store[free_stack_count[IDX_W-1:0]] <= req_block_addr;
    end
  end

  // Every accepted request yields one result, and no result appears without one.
  `ABPA_ASSERT(a_done_after_start, clk, rst, (start && !busy) |-> ##2 done, "result missing")
  `ABPA_ASSERT(a_done_has_request, clk, rst, done |-> $past(start && !busy, 2), "spurious result")
  // Cache fill never passes its depth.
  `ABPA_ASSERT(a_count_bound, clk, rst, free_stack_count <= CNT_W'(CACHE_DEPTH), "cache overfill")
  // The page counter only moves forward between resets.
  `ABPA_ASSERT(a_page_monotone, clk, rst, !$past(rst) |-> next_page >= $past(next_page), "counter went back")

endmodule

>>> rtl/core/abpa_bump.sv
// ---------------------------------------------------------------------------
// Bump datapath
// Pad the page counter to the alignment boundary, form the address and
// advance the counter with saturation; flag out of memory.
// ---------------------------------------------------------------------------
module abpa_bump import abpa_pkg::*; (
  input  logic [FIELD_W-1:0] base,
  input  logic [FIELD_W-1:0] size,
  input  logic [NP_W-1:0]    next_page,
  input  logic               aligned,
  input  logic [PCNT_W-1:0]  page_count,
  input  logic [ORDER_W-1:0] order,
  output bump_res_t          res
);

  logic [ORDER_W-1:0] ashift;
  logic [LOW_W-1:0]   low_sum;
  logic [LOW_W-1:0]   amask;
  logic [LOW_W-1:0]   off;
  logic [LOW_W-1:0]   pad_wide;
  logic [PAD_W-1:0]   pad;
  logic [PAGES_W-1:0] pages;
  logic [NP_W:0]      sum_pad;
  logic [NP_W:0]      sum_end;
  logic [NP_W-1:0]    np_pad;
  logic [NP_W-1:0]    np_end;
  logic [WIDE_W-1:0]  cur;
  logic [WIDE_W-1:0]  end_bytes;

  always_comb begin
    ashift = (order < ORDER_W'(STACK_ORDER)) ? order : ORDER_W'(STACK_ORDER);
    // Only the low bits of base + counter matter for the boundary offset.
    low_sum  = base[LOW_W-1:0] + (LOW_W'(next_page) << PAGE_BITS);
    amask    = (LOW_W'(1) << (ashift + ORDER_W'(PAGE_BITS))) - LOW_W'(1);
    off      = low_sum & amask;
    pad_wide = (off == '0) ? '0 : ((LOW_W'(1) << ashift) - (off >> PAGE_BITS));
    pad      = aligned ? PAD_W'(pad_wide) : '0;
    pages    = aligned ? (PAGES_W'(1) << order) : PAGES_W'(page_count);

    // Saturate once after the pad and once after the full advance.
    sum_pad = {1'b0, next_page} + (NP_W+1)'(pad);
    np_pad  = (sum_pad >= {1'b0, NP_MAX}) ? NP_MAX : sum_pad[NP_W-1:0];
    sum_end = sum_pad + (NP_W+1)'(pages);
    np_end  = (sum_end >= {1'b0, NP_MAX}) ? NP_MAX : sum_end[NP_W-1:0];

    cur       = WIDE_W'(base) + WIDE_W'({np_pad, {PAGE_BITS{1'b0}}});
    end_bytes = WIDE_W'({np_end, {PAGE_BITS{1'b0}}});

    res.oom       = end_bytes > WIDE_W'(size);
    res.addr      = res.oom ? '0 : (cur[FIELD_W-1:0] & ADDR_MASK[FIELD_W-1:0]);
    res.next_page = np_end;
  end

endmodule
